[rtl/pixel_upscale_2x_blend_lut_assert.svh]
// Assertion macros shared by the checker of the 2x upscaler.
// No dependencies; included by the checker file.
`ifndef PIXEL_UPSCALE_2X_BLEND_LUT_ASSERT_SVH
`define PIXEL_UPSCALE_2X_BLEND_LUT_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define PU2B_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define PU2B_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define PU2B_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pu2b_pkg.sv]
// Shared types and constants of the 2x pixel upscaler with blend table.
// No dependencies; imported by the top level and the checker.
package pu2b_pkg;

   localparam int PIXELS_PER_WORD = 4;   // active pixels per source word, 1 to 4
   localparam int PIX_W           = 8;
   localparam int WORD_SLOTS      = 4;   // pixel slots in a source word field
   localparam int WORD_W          = WORD_SLOTS * PIX_W;
   localparam int ROW_W           = 2 * WORD_W;
   localparam int TABLE_AW        = 2 * PIX_W;

   typedef enum logic {
      FUNC_SCALE = 1'b0,
      FUNC_WRITE = 1'b1
   } func_type;

   typedef enum logic {
      MODE_NEAREST = 1'b0,
      MODE_BLEND   = 1'b1
   } mode_type;

   // Request payload, last member in the lowest bits.
   typedef struct packed {
      logic [PIX_W-1:0]  entry_value;
      logic [PIX_W-1:0]  entry_second;
      logic [PIX_W-1:0]  entry_first;
      logic [WORD_W-1:0] lower_pixels;
      logic [PIX_W-1:0]  following_pixel;
      logic [WORD_W-1:0] upper_pixels;
   } req_data_type;

   typedef struct packed {
      logic [ROW_W-1:0] lower_out_row;
      logic [ROW_W-1:0] upper_out_row;
   } rsp_data_type;

   localparam int REQ_DATA_W = $bits(req_data_type);
   localparam int RSP_DATA_W = $bits(rsp_data_type);

endpackage

[rtl/pu2b_ram.sv]
// Simple RAM with one write port and two registered read ports.
// No dependencies; one copy per pixel lane holds the blend table.
module pu2b_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[rtl/pixel_upscale_2x_blend_lut.sv]
// Top level of the 2x pixel upscaler with a 256x256 blend table.
// Depends on pu2b_pkg and pu2b_ram.
//
//   port group   direction   tdata fields (low bit up)                        tuser
//   req_         in          upper_pixels, following_pixel, lower_pixels,     func
//                            entry_first, entry_second, entry_value
//   rsp_         out         upper_out_row, lower_out_row                     -
//   csr_         in          scale_mode (write only)                          -
//
// One item per cycle while rsp_tready is high. A scale item reaches rsp_tvalid after it passes
// through input register, blend table read register and output register.
// Table writes retire at the table read stage and give no transfer on rsp_.
// Reset clears the valid bits and scale_mode; the table contents are undefined until written.
// A stage holds only while the stage after it is full and does not move.
module pixel_upscale_2x_blend_lut
   import pu2b_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // upper_pixels, following_pixel, lower_pixels,
                                              // entry_first, entry_second, entry_value
   input  logic                  req_tuser,   // func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // upper_out_row, lower_out_row
   input  logic                  csr_we,
   input  logic                  csr_wdata    // scale_mode
);

   mode_type     mode_ff;
   logic         s1_valid_ff;
   func_type     s1_func_ff;
   req_data_type s1_data_ff;
   logic         s2_valid_ff;
   logic         s2_valid_in;
   logic [WORD_W-1:0] s2_upper_ff;
   logic         s3_valid_ff;
   rsp_data_type s3_data_ff;
   rsp_data_type s3_data_in;
   logic         load_s1;
   logic         load_s2;
   logic         load_s3;
   logic         table_we;

   logic [PIX_W-1:0]   blend_right [WORD_SLOTS];
   logic [PIX_W-1:0]   blend_below [WORD_SLOTS];
   logic [2*PIX_W-1:0] up_pair     [WORD_SLOTS];
   logic [2*PIX_W-1:0] low_pair    [WORD_SLOTS];

   // Each stage loads when it is empty or when the stage after it loads.
   assign load_s3 = !s3_valid_ff || rsp_tready;
   assign load_s2 = !s2_valid_ff || load_s3;
   assign load_s1 = !s1_valid_ff || load_s2;
   assign req_tready = load_s1;

   assign s2_valid_in = s1_valid_ff && (s1_func_ff == FUNC_SCALE);
   assign table_we = load_s2 && s1_valid_ff && (s1_func_ff == FUNC_WRITE);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NEAREST;
      end else if (csr_we) begin
         mode_ff <= mode_type'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (load_s1) begin
            s1_valid_ff <= req_tvalid;
         end
         if (load_s2) begin
            s2_valid_ff <= s2_valid_in;
         end
         if (load_s3) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_func_ff <= func_type'(req_tuser);
         s1_data_ff <= req_data_type'(req_tdata);
      end
      if (load_s2) begin
         s2_upper_ff <= s1_data_ff.upper_pixels;
      end
      if (load_s3) begin
         s3_data_ff <= s3_data_in;
      end
   end

   for (genvar k = 0; k < WORD_SLOTS; k++) begin : g_lane
      if (k < PIXELS_PER_WORD) begin : g_active
         logic [PIX_W-1:0] here_s1;
         logic [PIX_W-1:0] right_s1;
         logic [PIX_W-1:0] below_s1;
         logic [PIX_W-1:0] here_s2;

         assign here_s1  = s1_data_ff.upper_pixels[k*PIX_W +: PIX_W];
         assign below_s1 = s1_data_ff.lower_pixels[k*PIX_W +: PIX_W];
         if (k + 1 < PIXELS_PER_WORD) begin : g_inner
            assign right_s1 = s1_data_ff.upper_pixels[(k+1)*PIX_W +: PIX_W];
         end else begin : g_edge
            assign right_s1 = s1_data_ff.following_pixel;
         end

         // Every lane holds its own copy of the table so that all lanes read it in parallel.
         pu2b_ram #(
            .ADDR_W (TABLE_AW),
            .DATA_W (PIX_W)
         ) u_table (
            .clock     (clock),
            .wr_en     (table_we),
            .wr_addr   ({s1_data_ff.entry_first, s1_data_ff.entry_second}),
            .wr_data   (s1_data_ff.entry_value),
            .rd_en     (load_s2),
            .rd_addr_a ({here_s1, right_s1}),
            .rd_addr_b ({here_s1, below_s1}),
            .rd_data_a (blend_right[k]),
            .rd_data_b (blend_below[k])
         );

         assign here_s2 = s2_upper_ff[k*PIX_W +: PIX_W];

         always_comb begin
            if (mode_ff == MODE_BLEND) begin
               up_pair[k]  = {blend_right[k], here_s2};
               low_pair[k] = {blend_below[k], blend_below[k]};
            end else begin
               up_pair[k]  = {here_s2, here_s2};
               low_pair[k] = {here_s2, here_s2};
            end
         end
      end else begin : g_unused
         assign blend_right[k] = '0;
         assign blend_below[k] = '0;
         assign up_pair[k]     = '0;
         assign low_pair[k]    = '0;
      end
   end

   always_comb begin
      for (int k = 0; k < WORD_SLOTS; k++) begin
         s3_data_in.upper_out_row[k*2*PIX_W +: 2*PIX_W] = up_pair[k];
         s3_data_in.lower_out_row[k*2*PIX_W +: 2*PIX_W] = low_pair[k];
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = s3_data_ff;

endmodule

[rtl/pu2b_checker.sv]
// Port-level checks of the 2x pixel upscaler, attached by bind.
// Depends on pu2b_pkg and pixel_upscale_2x_blend_lut_assert.svh.
`include "pixel_upscale_2x_blend_lut_assert.svh"

module pu2b_checker
   import pu2b_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A result waiting for its transfer stays offered and unchanged.
   `PU2B_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp_tvalid dropped while stalled")
   `PU2B_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp_tdata changed while stalled")

   // When the output register is free or drains, the whole pipeline can move.
   `PU2B_ASSERT_NOW(a_req_flow, clock, reset, !rsp_tvalid || rsp_tready, req_tready, "req_tready low with a free output")

   `PU2B_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "result offered right after reset")

endmodule

bind pixel_upscale_2x_blend_lut pu2b_checker u_pu2b_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
